@@ design/b64lw_pkg.sv @@
package b64lw_pkg;

   localparam logic [4:0] GROUPS_PER_LINE = 5'd19;
   localparam logic [6:0] PAD_CHAR = 7'd61;
   localparam logic [6:0] NEWLINE_CHAR = 7'd10;

   localparam int QDEPTH = 2;
   localparam int QPTR_W = 1;
   localparam int QCNT_W = 2;

   localparam logic [2:0] IDX_S0 = 3'd0;
   localparam logic [2:0] IDX_S1 = 3'd1;
   localparam logic [2:0] IDX_S2 = 3'd2;
   localparam logic [2:0] IDX_S3 = 3'd3;
   localparam logic [2:0] IDX_NL = 3'd4;

   localparam logic [1:0] USED_ONE = 2'd1;
   localparam logic [1:0] USED_TWO = 2'd2;
   localparam logic [1:0] USED_THREE = 2'd3;

   localparam logic REG_LINE_WRAP = 1'b0;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [6:0] out_char;
      logic       last_char;
   } rsp_type;

   typedef struct packed {
      logic [23:0] group;
      logic [1:0]  used;
      logic        newline;
   } group_type;

   function automatic logic [6:0] b64_char(input logic [5:0] v);
      logic [6:0] c;
      if (v < 6'd26) begin
         c = 7'd65 + {1'b0, v};
      end else if (v < 6'd52) begin
         c = 7'd71 + {1'b0, v};
      end else if (v < 6'd62) begin
         c = {1'b0, v} - 7'd4;
      end else if (v == 6'd62) begin
         c = 7'd43;
      end else begin
         c = 7'd47;
      end
      return c;
   endfunction

endpackage

@@ design/base64_encoder_line_wrap.sv @@
// Channel   Direction  Handshake                 Payload
// req       in         req_valid / req_ready     req_data: in_byte, last_byte
// rsp       out        rsp_valid / rsp_ready     rsp_data: out_char, last_char
// csr       in         csr_psel / csr_penable    line_wrap at byte address 0
//
// A byte is taken in every cycle while the two-entry group queue has room.
// Each group gives four characters, or five with a newline, one per cycle
// from the output register while rsp_ready does not hold it.
// Synchronous reset clears the group state, the queue and the output valid.
// The input stalls only when the queue is full; the output stalls only on rsp_ready.
module base64_encoder_line_wrap import b64lw_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic      line_wrap_ff, line_wrap_in;
   logic      q_full;
   logic      push;
   group_type push_data;
   logic      pop;
   logic      head_valid;
   group_type head;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_LINE_WRAP) ? {31'd0, line_wrap_ff} : 32'd0;

   always_comb begin
      line_wrap_in = line_wrap_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready
          && csr_paddr[2] == REG_LINE_WRAP) begin
         line_wrap_in = csr_pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_wrap_ff <= 1'b0;
      end else begin
         line_wrap_ff <= line_wrap_in;
      end
   end

   b64lw_front u_front (
      .clock     (clock),
      .reset     (reset),
      .line_wrap (line_wrap_ff),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_full    (q_full),
      .push      (push),
      .push_data (push_data)
   );

   b64lw_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .pop        (pop),
      .full       (q_full),
      .head_valid (head_valid),
      .head       (head)
   );

   b64lw_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

@@ design/b64lw_front.sv @@
module b64lw_front import b64lw_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      line_wrap,
   input  logic      req_valid,
   output logic      req_ready,
   input  req_type   req_data,
   input  logic      q_full,
   output logic      push,
   output group_type push_data
);

   logic [15:0] held_ff, held_in;
   logic [1:0]  count_ff, count_in;
   logic [4:0]  groups_left_ff, groups_left_in;
   logic        accept;
   logic [1:0]  used;
   logic [15:0] held_new;
   logic        newline;

   assign req_ready = !q_full;
   assign accept = req_valid && req_ready;

   always_comb begin
      held_new = held_ff;
      used = USED_THREE;
      priority if (count_ff == 2'd0) begin
         held_new = {req_data.in_byte, 8'h00};
         used = USED_ONE;
      end else if (count_ff == 2'd1) begin
         held_new = {held_ff[15:8], req_data.in_byte};
         used = USED_TWO;
      end
      newline = line_wrap && ((groups_left_ff <= 5'd1) || req_data.last_byte);
      push = accept && ((used == USED_THREE) || req_data.last_byte);
      push_data.used = used;
      push_data.newline = newline;
      if (used == USED_THREE) begin
         push_data.group = {held_ff, req_data.in_byte};
      end else begin
         push_data.group = {held_new, 8'h00};
      end
      held_in = held_ff;
      count_in = count_ff;
      groups_left_in = groups_left_ff;
      if (push) begin
         held_in = 16'h0000;
         count_in = 2'd0;
         if (line_wrap) begin
            if (newline) begin
               groups_left_in = GROUPS_PER_LINE;
            end else begin
               groups_left_in = groups_left_ff - 5'd1;
            end
         end
         if (req_data.last_byte) begin
            groups_left_in = GROUPS_PER_LINE;
         end
      end else if (accept) begin
         held_in = held_new;
         count_in = used;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= 16'h0000;
         count_ff <= 2'd0;
         groups_left_ff <= GROUPS_PER_LINE;
      end else begin
         held_ff <= held_in;
         count_ff <= count_in;
         groups_left_ff <= groups_left_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("byte count reached three");
   a_partial_push_last: assert property (@(posedge clock) disable iff (reset)
      push && push_data.used != USED_THREE |-> req_data.last_byte)
      else $error("short group pushed without message end");
   a_counter_nonzero: assert property (@(posedge clock) disable iff (reset)
      push && req_data.last_byte |=> groups_left_ff == GROUPS_PER_LINE)
      else $error("line counter not reloaded at message end");
`endif

endmodule

@@ design/b64lw_queue.sv @@
module b64lw_queue import b64lw_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  group_type push_data,
   input  logic      pop,
   output logic      full,
   output logic      head_valid,
   output group_type head
);

   group_type          entries_ff [QDEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;

   assign full = (count_ff == QCNT_W'(QDEPTH));
   assign head_valid = (count_ff != '0);
   assign head = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("push into a full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("pop from an empty queue");
   a_count_ptrs: assert property (@(posedge clock) disable iff (reset)
      (count_ff == QCNT_W'(1)) |-> (wr_ptr_ff != rd_ptr_ff))
      else $error("queue pointers disagree with count");
`endif

endmodule

@@ design/b64lw_back.sv @@
module b64lw_back import b64lw_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      head_valid,
   input  group_type head,
   output logic      pop,
   output logic      rsp_valid,
   input  logic      rsp_ready,
   output rsp_type   rsp_data
);

   logic [2:0] idx_ff, idx_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_data_ff, rsp_data_in;
   logic       load;
   logic       final_char;
   logic [6:0] char_sel;

   assign load = !rsp_valid_ff || rsp_ready;
   assign final_char = head.newline ? (idx_ff == IDX_NL) : (idx_ff == IDX_S3);

   always_comb begin
      unique case (idx_ff)
         IDX_S0: char_sel = b64_char(head.group[23:18]);
         IDX_S1: char_sel = b64_char(head.group[17:12]);
         IDX_S2: char_sel = (head.used != USED_ONE) ? b64_char(head.group[11:6]) : PAD_CHAR;
         IDX_S3: char_sel = (head.used == USED_THREE) ? b64_char(head.group[5:0]) : PAD_CHAR;
         default: char_sel = NEWLINE_CHAR;
      endcase
   end

   always_comb begin
      pop = 1'b0;
      idx_in = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in = rsp_data_ff;
      if (load) begin
         rsp_valid_in = head_valid;
         if (head_valid) begin
            rsp_data_in.out_char = char_sel;
            rsp_data_in.last_char = final_char;
            pop = final_char;
            idx_in = final_char ? IDX_S0 : idx_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= IDX_S0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

`ifndef NO_ASSERTIONS
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= IDX_NL)
      else $error("character index out of range");
   a_nl_only_wrapped: assert property (@(posedge clock) disable iff (reset)
      head_valid && idx_ff == IDX_NL |-> head.newline)
      else $error("newline slot reached without newline request");
   a_last_on_pop: assert property (@(posedge clock) disable iff (reset)
      pop |=> rsp_valid && rsp_data.last_char)
      else $error("group retired without a last character");
`endif

endmodule
